>>> sv/rssi_neighbor_table_with_aging_defines.svh
// Assertion macros for the neighbour table checker
`ifndef RSSI_NEIGHBOR_TABLE_WITH_AGING_DEFINES_SVH
`define RSSI_NEIGHBOR_TABLE_WITH_AGING_DEFINES_SVH

// checked only outside reset
`define RSSI_NT_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every edge, reset included
`define RSSI_NT_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

>>> sv/rssi_nt_pkg.sv
// Shared types and constants for the neighbour sighting table
`timescale 1ns / 1ps

package rssi_nt_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QFILL_W     = 2;

   localparam int REQ_DATA_W  = 72;
   localparam int RSP_DATA_W  = 8;

   localparam logic [31:0]       STALE_RESET  = 32'd3000;
   localparam logic signed [7:0] UNKNOWN_RSSI = -8'sd127;

   typedef enum logic [0:0] {
      OP_RECORD = 1'b0,
      OP_QUERY  = 1'b1
   } op_type;

   typedef struct packed {
      op_type             op;
      logic [31:0]        device_id;
      logic signed [7:0]  rssi;
      logic [31:0]        now_ms;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } q_item_type;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_FINISH = 3'b100
   } back_state_type;

endpackage

>>> sv/rssi_nt_front.sv
// Input stage: takes items off the request stream and decodes them into commands
`timescale 1ns / 1ps

module rssi_nt_front import rssi_nt_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic                  req_tuser,   // mode
   input  logic [REQ_DATA_W-1:0] req_tdata,   // device_id, rssi, now_ms
   output q_item_type            push_o,
   input  logic                  push_ready
);

   logic    valid_ff, valid_in;
   cmd_type cmd_ff, cmd_in;
   logic    req_accept;
   op_type  op_dec;

   assign req_tready = !valid_ff || push_ready;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      unique case (req_tuser)
         1'b0:    op_dec = OP_RECORD;
         1'b1:    op_dec = OP_QUERY;
         default: op_dec = OP_RECORD;
      endcase
   end

   always_comb begin
      valid_in = valid_ff && !push_ready;
      cmd_in   = cmd_ff;
      if (req_accept) begin
         valid_in         = 1'b1;
         cmd_in.op        = op_dec;
         cmd_in.device_id = req_tdata[31:0];
         cmd_in.rssi      = req_tdata[39:32];
         cmd_in.now_ms    = req_tdata[71:40];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      cmd_ff <= cmd_in;
   end

   assign push_o.valid = valid_ff;
   assign push_o.cmd   = cmd_ff;

endmodule

>>> sv/rssi_nt_queue.sv
// Two-entry command queue between the input stage and the table engine
`timescale 1ns / 1ps

module rssi_nt_queue import rssi_nt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  q_item_type push_i,
   output logic       push_ready,
   output q_item_type pop_o,
   input  logic       pop_ready
);

   cmd_type            entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QFILL_W-1:0] fill_ff, fill_in;
   logic               do_push, do_pop;

   assign push_ready = fill_ff != QFILL_W'(QUEUE_DEPTH);
   assign do_push    = push_i.valid && push_ready;
   assign pop_o.valid = fill_ff != '0;
   assign pop_o.cmd   = entry_ff[rd_ptr_ff];
   assign do_pop     = pop_o.valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_i.cmd;
      end
   end

endmodule

>>> sv/rssi_nt_back.sv
// Table engine: scans the sighting table, updates or appends entries and answers queries
`timescale 1ns / 1ps

module rssi_nt_back import rssi_nt_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  q_item_type            pop_i,
   output logic                  pop_ready,
   input  logic                  csr_we,
   input  logic [31:0]           csr_wdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   back_state_type    state_ff, state_in;
   cmd_type           cmd_ff, cmd_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              hit_ff, hit_in;
   logic [IDX_W-1:0]  slot_ff, slot_in;
   logic signed [7:0] hit_rssi_ff, hit_rssi_in;
   logic [31:0]       age_ff, age_in;
   logic [31:0]       stale_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic signed [7:0] rsp_data_ff, rsp_data_in;

   logic [31:0]       id_mem    [TABLE_DEPTH];
   logic signed [7:0] rssi_mem  [TABLE_DEPTH];
   logic [31:0]       stamp_mem [TABLE_DEPTH];
   logic [31:0]       rd_id_ff;
   logic signed [7:0] rd_rssi_ff;
   logic [31:0]       rd_stamp_ff;

   logic [CNT_W-1:0]  rd_addr;
   logic [CNT_W-1:0]  idx_next;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;

   assign pop_ready = state_ff == ST_IDLE;
   assign idx_next  = idx_ff + 1'b1;

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      idx_in       = idx_ff;
      count_in     = count_ff;
      hit_in       = hit_ff;
      slot_in      = slot_ff;
      hit_rssi_in  = hit_rssi_ff;
      age_in       = age_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rd_addr      = idx_next;
      wr_en        = 1'b0;
      wr_addr      = slot_ff;

      unique case (state_ff)
         ST_IDLE: begin
            rd_addr = '0;
            if (pop_i.valid) begin
               cmd_in   = pop_i.cmd;
               idx_in   = '0;
               hit_in   = 1'b0;
               state_in = (count_ff == '0) ? ST_FINISH : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (rd_id_ff == cmd_ff.device_id) begin
               hit_in      = 1'b1;
               slot_in     = idx_ff[IDX_W-1:0];
               hit_rssi_in = rd_rssi_ff;
               age_in      = cmd_ff.now_ms - rd_stamp_ff;
               state_in    = ST_FINISH;
            end else if (idx_next == count_ff) begin
               state_in = ST_FINISH;
            end else begin
               idx_in = idx_next;
            end
         end
         ST_FINISH: begin
            if (cmd_ff.op == OP_RECORD) begin
               if (hit_ff) begin
                  wr_en = 1'b1;
               end else if (count_ff < CNT_W'(TABLE_DEPTH)) begin
                  wr_en    = 1'b1;
                  wr_addr  = count_ff[IDX_W-1:0];
                  count_in = count_ff + 1'b1;
               end
               state_in = ST_IDLE;
            end else if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = (hit_ff && (age_ff < stale_ff)) ? hit_rssi_ff : UNKNOWN_RSSI;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         stale_ff     <= STALE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            stale_ff <= csr_wdata;
         end
      end
      cmd_ff      <= cmd_in;
      idx_ff      <= idx_in;
      hit_ff      <= hit_in;
      slot_ff     <= slot_in;
      hit_rssi_ff <= hit_rssi_in;
      age_ff      <= age_in;
      rsp_data_ff <= rsp_data_in;
   end

   // table storage, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         id_mem[wr_addr]    <= cmd_ff.device_id;
         rssi_mem[wr_addr]  <= cmd_ff.rssi;
         stamp_mem[wr_addr] <= cmd_ff.now_ms;
      end
      rd_id_ff    <= id_mem[rd_addr[IDX_W-1:0]];
      rd_rssi_ff  <= rssi_mem[rd_addr[IDX_W-1:0]];
      rd_stamp_ff <= stamp_mem[rd_addr[IDX_W-1:0]];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> sv/rssi_neighbor_table_with_aging.sv
// Neighbour sighting table with aging: top level
//
// Keeps up to 16 device sightings (id, strength, time stamp). A record item (tuser 0)
// updates the entry with the same id or appends one while there is room; it gives no
// result. A query item (tuser 1) gives one result: the stored strength when
// (now_ms - stamp) mod 2^32 is below stale_ms, else -127. stale_ms resets to 3000
// and is written through csr_we/csr_wdata; the user must write it only while the
// block is idle, which the block itself does not enforce. The table engine takes
// one item at a time and scans the filled entries until the id is found, reading one
// entry a cycle from a single read port. A two-entry queue sits between the input
// stage and the table engine, and the result register lets a finished result wait.
`timescale 1ns / 1ps

module rssi_neighbor_table_with_aging import rssi_nt_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic                  req_tuser,   // mode
   input  logic [REQ_DATA_W-1:0] req_tdata,   // device_id[31:0], rssi[39:32], now_ms[71:40]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // rssi_reported[7:0]
   input  logic                  csr_we,
   input  logic [31:0]           csr_wdata    // stale_ms
);

   q_item_type push_item;
   logic       push_ready;
   q_item_type pop_item;
   logic       pop_ready;

   rssi_nt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .push_o     (push_item),
      .push_ready (push_ready)
   );

   rssi_nt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_i     (push_item),
      .push_ready (push_ready),
      .pop_o      (pop_item),
      .pop_ready  (pop_ready)
   );

   rssi_nt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_i      (pop_item),
      .pop_ready  (pop_ready),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

>>> sv/rssi_nt_checker.sv
// Port-level checker for the neighbour sighting table, bound to the top level
`timescale 1ns / 1ps
`include "rssi_neighbor_table_with_aging_defines.svh"

module rssi_nt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata
);

   // front stage, queue, engine and result register
   localparam logic [3:0] PEND_MAX = 4'd5;

   logic [3:0] pend_ff, pend_in;
   logic       query_acc, rsp_acc;
   logic       rsp_stall;

   assign query_acc = req_tvalid && req_tready && req_tuser;
   assign rsp_acc   = rsp_tvalid && rsp_tready;
   assign rsp_stall = rsp_tvalid && !rsp_tready;

   always_comb begin
      pend_in = pend_ff;
      if (query_acc && !rsp_acc) begin
         pend_in = pend_ff + 1'b1;
      end else if (rsp_acc && !query_acc) begin
         pend_in = pend_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   `RSSI_NT_ASSERT(a_rsp_hold, rsp_stall |=> rsp_tvalid && $stable(rsp_tdata), "rsp not held")
   `RSSI_NT_ASSERT(a_rsp_has_query, rsp_tvalid |-> pend_ff != 4'd0, "result with no query")
   `RSSI_NT_ASSERT(a_pend_bound, pend_ff <= PEND_MAX, "too many queries in flight")
   `RSSI_NT_ASSERT_ALWAYS(a_reset_quiet, reset |=> !rsp_tvalid, "result valid after reset")

endmodule

bind rssi_neighbor_table_with_aging rssi_nt_checker u_checker (.*);

>>> sim/tb_rssi_neighbor_table_with_aging.sv
// Self-checking testbench for the neighbour sighting table with aging
`timescale 1ns / 1ps

module tb_rssi_neighbor_table_with_aging;
   import rssi_nt_pkg::*;

   localparam int POOL_SIZE   = 20;
   localparam int PHASE_ITEMS = 333;
   localparam int SETTLE      = 4 * (TABLE_DEPTH + 2) + 30;
   localparam int HOLD_CYCLES = 500;
   localparam int IDLE_PCT    = 24;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic                  req_tuser = 1'b0;              // mode
   logic [REQ_DATA_W-1:0] req_tdata = '0;                // device_id, rssi, now_ms
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;                     // rssi_reported
   logic                  csr_we = 1'b0;
   logic [31:0]           csr_wdata = '0;                // stale_ms

   rssi_neighbor_table_with_aging dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // predicted table contents
   logic [31:0]       nbr_id    [TABLE_DEPTH];
   logic signed [7:0] nbr_rssi  [TABLE_DEPTH];
   logic [31:0]       nbr_stamp [TABLE_DEPTH];
   int                nbr_fill = 0;
   logic [31:0]       stale_limit = STALE_RESET;

   cmd_type           pending_cmds [$];
   logic signed [7:0] expected_rssi [$];
   int                queued_count = 0;
   int                accepted_count = 0;
   int                fault_count = 0;
   logic              req_fired = 1'b0;
   bit                steady_flow = 1'b0;
   bit                hold_request = 1'b0;
   int                hold_left = 0;

   // stimulus-side bookkeeping
   logic [31:0] id_pool   [POOL_SIZE];
   logic [31:0] pool_seen [POOL_SIZE];
   logic [31:0] clock_ms;

   function automatic bit apply_sighting(input cmd_type c, output logic signed [7:0] reported);
      int          hit;
      int          k;
      logic [31:0] age;
      hit = -1;
      reported = UNKNOWN_RSSI;
      for (k = 0; k < nbr_fill; k++) begin
         if (hit < 0 && nbr_id[k] == c.device_id) hit = k;
      end
      if (c.op == OP_RECORD) begin
         if (hit < 0 && nbr_fill < TABLE_DEPTH) begin
            hit = nbr_fill;
            nbr_id[hit] = c.device_id;
            nbr_fill++;
         end
         if (hit >= 0) begin
            nbr_rssi[hit] = c.rssi;
            nbr_stamp[hit] = c.now_ms;
         end
         return 1'b0;
      end
      if (hit >= 0) begin
         age = c.now_ms - nbr_stamp[hit];
         if (age < stale_limit) reported = nbr_rssi[hit];
      end
      return 1'b1;
   endfunction

   task automatic queue_record(input logic [31:0] id, input logic signed [7:0] rssi,
                               input logic [31:0] now);
      cmd_type c;
      int      k;
      c.op = OP_RECORD;
      c.device_id = id;
      c.rssi = rssi;
      c.now_ms = now;
      pending_cmds.push_back(c);
      queued_count++;
      for (k = 0; k < POOL_SIZE; k++) begin
         if (id_pool[k] == id) pool_seen[k] = now;
      end
   endtask

   task automatic queue_query(input logic [31:0] id, input logic [31:0] now);
      cmd_type c;
      c.op = OP_QUERY;
      c.device_id = id;
      c.rssi = 8'($urandom);
      c.now_ms = now;
      pending_cmds.push_back(c);
      queued_count++;
   endtask

   task automatic queue_random_item(input logic [31:0] stale);
      int          idx;
      logic [31:0] id;
      logic [31:0] base;
      logic [31:0] delta;
      idx = $urandom_range(0, POOL_SIZE - 1);
      id = id_pool[idx];
      base = pool_seen[idx];
      if ($urandom_range(0, 99) < 8) begin
         id = $urandom;
         base = $urandom;
      end
      if ($urandom_range(0, 1) == 0) begin
         if ($urandom_range(0, 19) == 0) clock_ms = $urandom;
         else clock_ms = clock_ms + $urandom_range(0, 2000);
         queue_record(id, 8'($urandom), clock_ms);
      end else begin
         case ($urandom_range(0, 5))
            0: delta = stale - 1;
            1: delta = stale;
            2: delta = stale + 1;
            3: delta = $urandom_range(0, stale);
            4: delta = $urandom;
            default: delta = '0;
         endcase
         queue_query(id, base + delta);
      end
   endtask

   task automatic drain_block;
      while (accepted_count != queued_count || expected_rssi.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   // driver
   always @(negedge clock) begin
      cmd_type next_cmd;
      if (!reset && (!req_tvalid || req_fired)) begin
         if (pending_cmds.size() != 0 && (steady_flow || $urandom_range(0, 99) >= IDLE_PCT)) begin
            next_cmd = pending_cmds.pop_front();
            req_tvalid <= 1'b1;
            req_tuser <= next_cmd.op;
            req_tdata <= {next_cmd.now_ms, next_cmd.rssi, next_cmd.device_id};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver, with a long hold-off on request
   always @(negedge clock) begin
      if (hold_request) begin
         hold_left = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   // accepted items and register writes feed the predictor
   always @(posedge clock) begin
      cmd_type           taken;
      logic signed [7:0] want;
      if (reset) begin
         req_fired <= 1'b0;
      end else begin
         if (csr_we) stale_limit = csr_wdata;
         req_fired <= req_tvalid && req_tready;
         if (req_tvalid && req_tready) begin
            taken.op = op_type'(req_tuser);
            taken.device_id = req_tdata[31:0];
            taken.rssi = req_tdata[39:32];
            taken.now_ms = req_tdata[71:40];
            accepted_count++;
            if (apply_sighting(taken, want)) expected_rssi.push_back(want);
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      logic signed [7:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_rssi.size() == 0) begin
            fault_count++;
            if (fault_count <= 10)
               $display("unexpected result: rssi_reported %0d", $signed(rsp_tdata));
         end else begin
            want = expected_rssi.pop_front();
            if (rsp_tdata !== want) begin
               fault_count++;
               if (fault_count <= 10)
                  $display("rssi_reported mismatch: expected %0d, got %0d",
                           want, $signed(rsp_tdata));
            end
         end
      end
   end

   initial begin
      logic [31:0] stale_plan [6];
      int          p;
      int          n;
      int          k;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      id_pool[0] = 32'h0000_0000;
      id_pool[1] = 32'hFFFF_FFFF;
      for (k = 2; k < POOL_SIZE; k++) id_pool[k] = $urandom;
      for (k = 0; k < POOL_SIZE; k++) pool_seen[k] = $urandom;
      clock_ms = 32'hFFFF_F000;

      // directed part at the reset staleness limit
      queue_query(id_pool[0], 32'd0);                          // empty table
      queue_record(id_pool[0], -8'sd128, 32'hFFFF_FF00);
      queue_record(id_pool[1], 8'sd127, 32'hFFFF_FFFF);
      queue_query(id_pool[0], 32'hFFFF_FF00 + 32'd2999);       // fresh across the wrap
      queue_query(id_pool[0], 32'hFFFF_FF00 + 32'd3000);       // age equals limit
      queue_query(id_pool[1], 32'd2998);
      queue_record(id_pool[0], 8'sd0, 32'd100);                 // update in place
      queue_query(id_pool[0], 32'd100);
      for (k = 2; k < TABLE_DEPTH; k++) queue_record(id_pool[k], 8'($urandom), k * 50);
      queue_record(id_pool[TABLE_DEPTH], 8'sd55, 32'd900);      // table full, dropped
      queue_query(id_pool[TABLE_DEPTH], 32'd900);
      drain_block();

      stale_plan[0] = 32'd0;
      stale_plan[1] = 32'hFFFF_FFFF;
      stale_plan[2] = 32'd1;
      stale_plan[3] = STALE_RESET;
      stale_plan[4] = $urandom_range(50, 20000);
      stale_plan[5] = $urandom;

      for (p = 0; p < 6; p++) begin
         csr_we <= 1'b1;
         csr_wdata <= stale_plan[p];
         @(negedge clock);
         csr_we <= 1'b0;
         steady_flow = (p == 3);
         if (p == 4) hold_request = 1'b1;
         for (n = 0; n < PHASE_ITEMS; n++) queue_random_item(stale_plan[p]);
         drain_block();
         steady_flow = 1'b0;
      end

      if (fault_count == 0 && expected_rssi.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
